// ===== hw/rtl/pdp_pkg.sv =====
package pdp_pkg;

  localparam int TOTAL_BITS = 48;
  localparam int LIMIT_BITS = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic fill;
  } step_ctl_t;

endpackage

// ===== hw/rtl/partition_max_sum_dp_core.sv =====
// An input beat starts a scan over n window entries, where n is the
// smaller of group_limit and the number of items so far in the sequence.
// No new item is taken until the result beat is committed; the scan uses the
// shared max, multiply and add unit that steps through one window entry a cycle.
// Reset clears the sequence history and sets group_limit to 1.
module partition_max_sum_dp_core #(
  parameter int MAX_GROUP  = 16,
  parameter int VALUE_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [VALUE_BITS-1:0]              in_value,
  input  logic                               in_start_new,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pdp_pkg::TOTAL_BITS-1:0]     out_best_total,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pdp_pkg::LIMIT_BITS-1:0]     cfg_group_limit
);

  localparam int IDX_BITS = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [pdp_pkg::LIMIT_BITS-1:0]  limit_r, limit_nxt;
  logic [VALUE_BITS-1:0]           value_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [pdp_pkg::TOTAL_BITS-1:0]  out_best_r;
  pdp_pkg::step_ctl_t              ctl;
  logic [IDX_BITS-1:0]             idx;
  logic                            commit;
  logic                            busy;
  logic                            out_free;
  logic [VALUE_BITS-1:0]           win_value;
  logic [pdp_pkg::TOTAL_BITS-1:0]  win_best;
  logic [pdp_pkg::TOTAL_BITS-1:0]  best;

  assign cfg_ready      = 1'b1;
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_best_total = out_best_r;

  always_comb begin
    limit_nxt     = cfg_valid ? cfg_group_limit : limit_r;
    out_valid_nxt = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= pdp_pkg::LIMIT_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      value_r <= in_value;
    end
    if (commit) begin
      out_best_r <= best;
    end
  end

  pdp_seq #(
    .MAX_GROUP(MAX_GROUP)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_start_new(in_start_new),
    .limit       (limit_r),
    .busy        (busy),
    .out_free    (out_free),
    .in_ready    (in_ready),
    .ctl         (ctl),
    .idx         (idx),
    .commit      (commit)
  );

  pdp_window #(
    .MAX_GROUP (MAX_GROUP),
    .VALUE_BITS(VALUE_BITS)
  ) u_window (
    .clk        (clk),
    .shift_en   (commit),
    .shift_value(value_r),
    .shift_best (best),
    .rd_idx     (idx),
    .rd_value   (win_value),
    .rd_best    (win_best)
  );

  pdp_unit #(
    .MAX_GROUP (MAX_GROUP),
    .VALUE_BITS(VALUE_BITS)
  ) u_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .idx      (idx),
    .cur_value(value_r),
    .win_value(win_value),
    .win_best (win_best),
    .busy     (busy),
    .best     (best)
  );

endmodule

// ===== hw/rtl/pdp_window.sv =====
module pdp_window #(
  parameter int MAX_GROUP  = 16,
  parameter int VALUE_BITS = 20
) (
  input  logic                                clk,
  input  logic                                shift_en,
  input  logic [VALUE_BITS-1:0]               shift_value,
  input  logic [pdp_pkg::TOTAL_BITS-1:0]      shift_best,
  input  logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] rd_idx,
  output logic [VALUE_BITS-1:0]               rd_value,
  output logic [pdp_pkg::TOTAL_BITS-1:0]      rd_best
);

  localparam int IDX_BITS  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int VW_DEPTH  = (MAX_GROUP > 1) ? MAX_GROUP - 1 : 1;
  localparam int VIDX_BITS = (VW_DEPTH > 1) ? $clog2(VW_DEPTH) : 1;

  logic [VALUE_BITS-1:0]          vw_r [VW_DEPTH];
  logic [pdp_pkg::TOTAL_BITS-1:0] bw_r [MAX_GROUP];
  logic [IDX_BITS-1:0]            vsel;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = VW_DEPTH - 1; k > 0; k--) begin
        vw_r[k] <= vw_r[k-1];
      end
      for (int k = MAX_GROUP - 1; k > 0; k--) begin
        bw_r[k] <= bw_r[k-1];
      end
      vw_r[0] <= shift_value;
      bw_r[0] <= shift_best;
    end
  end

  // The value of the item j back is read one entry lower than the best sum of the item before it.
  assign vsel     = (rd_idx == '0) ? '0 : rd_idx - IDX_BITS'(1);
  assign rd_value = vw_r[vsel[VIDX_BITS-1:0]];
  assign rd_best  = bw_r[rd_idx];

endmodule

// ===== hw/rtl/pdp_unit.sv =====
module pdp_unit #(
  parameter int MAX_GROUP  = 16,
  parameter int VALUE_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pdp_pkg::step_ctl_t                  ctl,
  input  logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] idx,
  input  logic [VALUE_BITS-1:0]               cur_value,
  input  logic [VALUE_BITS-1:0]               win_value,
  input  logic [pdp_pkg::TOTAL_BITS-1:0]      win_best,
  output logic                                busy,
  output logic [pdp_pkg::TOTAL_BITS-1:0]      best
);

  localparam int CNT_BITS  = $clog2(MAX_GROUP + 1);
  localparam int PROD_BITS = VALUE_BITS + CNT_BITS;
  localparam int TB        = pdp_pkg::TOTAL_BITS;

  logic                  a_v_r, a_v_nxt;
  logic                  b_v_r, b_v_nxt;
  logic [VALUE_BITS-1:0] run_max_r, run_max_nxt;
  logic [CNT_BITS-1:0]   fac_r, fac_nxt;
  logic [TB-1:0]         bwa_r, bwa_nxt;
  logic [PROD_BITS-1:0]  prod_r, prod_nxt;
  logic [TB-1:0]         bwb_r;
  logic [TB-1:0]         best_r, best_nxt;
  logic [TB:0]           sum;
  logic [TB-1:0]         cand;

  always_comb begin
    if (ctl.first) begin
      run_max_nxt = cur_value;
    end else if (win_value > run_max_r) begin
      run_max_nxt = win_value;
    end else begin
      run_max_nxt = run_max_r;
    end
    fac_nxt  = CNT_BITS'(idx) + CNT_BITS'(1);
    bwa_nxt  = ctl.fill ? win_best : '0;
    a_v_nxt  = ctl.issue;
    b_v_nxt  = a_v_r;
    prod_nxt = PROD_BITS'(run_max_r) * PROD_BITS'(fac_r);
    sum      = {1'b0, bwb_r} + (TB + 1)'(prod_r);
    cand     = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
    if (ctl.issue && ctl.first) begin
      best_nxt = '0;
    end else if (b_v_r && (cand > best_r)) begin
      best_nxt = cand;
    end else begin
      best_nxt = best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      run_max_r <= run_max_nxt;
      fac_r     <= fac_nxt;
      bwa_r     <= bwa_nxt;
    end
    prod_r <= prod_nxt;
    bwb_r  <= bwa_r;
    best_r <= best_nxt;
  end

  assign busy = a_v_r | b_v_r;
  assign best = best_r;

endmodule

// ===== hw/rtl/pdp_seq.sv =====
module pdp_seq #(
  parameter int MAX_GROUP = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_start_new,
  input  logic [pdp_pkg::LIMIT_BITS-1:0]     limit,
  input  logic                               busy,
  input  logic                               out_free,
  output logic                               in_ready,
  output pdp_pkg::step_ctl_t                 ctl,
  output logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] idx,
  output logic                               commit
);

  localparam int IDX_BITS = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_BITS = $clog2(MAX_GROUP + 1);
  localparam int LW = (CNT_BITS > pdp_pkg::LIMIT_BITS) ? CNT_BITS : pdp_pkg::LIMIT_BITS;

  pdp_pkg::state_t       state_r, state_nxt;
  logic [IDX_BITS-1:0]   j_r, j_nxt;
  logic [IDX_BITS-1:0]   last_r, last_nxt;
  logic [CNT_BITS-1:0]   seen_r, seen_nxt;
  logic                  accept;
  logic                  last_step;
  logic [LW-1:0]         glim;
  logic [LW-1:0]         gm1;
  logic [LW-1:0]         seen_w;

  always_comb begin
    in_ready  = (state_r == pdp_pkg::ST_IDLE);
    accept    = in_ready && in_valid;
    ctl.issue = (state_r == pdp_pkg::ST_SCAN);
    ctl.first = (j_r == '0);
    ctl.fill  = (CNT_BITS'(j_r) < seen_r);
    last_step = ctl.issue && (j_r == last_r);
    commit    = (state_r == pdp_pkg::ST_DRAIN) && !busy && out_free;
    idx       = j_r;
  end

  always_comb begin
    case (state_r)
      pdp_pkg::ST_IDLE:  state_nxt = accept ? pdp_pkg::ST_SCAN : pdp_pkg::ST_IDLE;
      pdp_pkg::ST_SCAN:  state_nxt = last_step ? pdp_pkg::ST_DRAIN : pdp_pkg::ST_SCAN;
      pdp_pkg::ST_DRAIN: state_nxt = commit ? pdp_pkg::ST_IDLE : pdp_pkg::ST_DRAIN;
      default:           state_nxt = pdp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    j_nxt    = j_r;
    last_nxt = last_r;
    seen_nxt = seen_r;
    glim     = LW'(limit);
    if (glim == '0) begin
      glim = LW'(1);
    end
    if (glim > LW'(MAX_GROUP)) begin
      glim = LW'(MAX_GROUP);
    end
    gm1    = glim - LW'(1);
    seen_w = in_start_new ? '0 : LW'(seen_r);
    if (accept) begin
      j_nxt    = '0;
      seen_nxt = CNT_BITS'(seen_w);
      last_nxt = (gm1 < seen_w) ? IDX_BITS'(gm1) : IDX_BITS'(seen_w);
    end else if (ctl.issue) begin
      j_nxt = j_r + IDX_BITS'(1);
    end else if (commit && (seen_r != CNT_BITS'(MAX_GROUP))) begin
      seen_nxt = seen_r + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdp_pkg::ST_IDLE;
      j_r     <= '0;
      last_r  <= '0;
      seen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// ===== hw/rtl/pdp_checker.sv =====
module pdp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pdp_pkg::TOTAL_BITS-1:0] out_best_total
);

  // An accepted beat keeps the input side closed while the block scans and drains.
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted too soon after previous beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_best_total)))
    else $error("stalled result beat changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("reset did not empty the block");

endmodule

bind partition_max_sum_dp_core pdp_checker u_pdp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_best_total(out_best_total)
);
